/* hw/rtl/svbd_pkg.sv */
// Shared types and constants for the signed variable-length integer decoder.
package svbd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned LenW    = 3;
  localparam int unsigned LeftW   = 3;
  localparam int unsigned OutPayW = ValueW + LenW;
  localparam int unsigned OutDataW = ((OutPayW + 7) / 8) * 8;

  localparam logic [LenW-1:0] LenOneByte = 3'd1;

  typedef enum logic [1:0] {
    FMT_12 = 2'd0,
    FMT_20 = 2'd1,
    FMT_28 = 2'd2,
    FMT_32 = 2'd3
  } fmt_e;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [LeftW-1:0]  left;
    fmt_e              kind;
  } dec_state_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   len;
  } dec_result_t;

endpackage

/* hw/rtl/signed_varint_byte_decoder.sv */
// Top level of the signed variable-length integer byte decoder.
//
// Channel   Dir  tdata fields (low bit first)
// s_axis    in   data_byte[7:0]
// m_axis    out  decoded_value[31:0], code_length[34:32], zero pad [39:35]
//
// One byte is taken per cycle; a result appears in the cycle after the byte that
// completes its code. The decode is a single pass of logic into the output register.
// Reset returns the decoder to waiting for a lead byte with an empty output.
// A stalled output holds its result and blocks input until it is taken.
module signed_varint_byte_decoder
  import svbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // data_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // decoded_value, code_length
);

  dec_state_t  state_q, state_d, step_state;
  dec_result_t step_res, out_res;
  logic        step_valid, in_fire;

  svbd_step u_step (
    .state_i     (state_q),
    .byte_i      (s_axis_tdata_i),
    .state_o     (step_state),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign state_d = in_fire ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  svbd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s_axis_tvalid_i && step_valid),
    .res_i       (step_res),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {{(OutDataW-OutPayW){1'b0}}, out_res.len, out_res.value};

`ifndef SYNTH
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.left <= LeftW'(4))
    else $error("continuation count out of range");

  a_last_byte_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.left == LeftW'(1)) |=> m_axis_tvalid_o)
    else $error("completed code produced no result");

  a_mid_byte_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.left > LeftW'(1) && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("result emitted inside a code");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_res.len != '0 && out_res.len <= LenW'(5)))
    else $error("code length out of range");
`endif

endmodule

/* hw/rtl/svbd_step.sv */
// Combinational decode of one byte against the current decoder state.
module svbd_step
  import svbd_pkg::*;
(
  input  dec_state_t        state_i,
  input  logic [ByteW-1:0]  byte_i,
  output dec_state_t        state_o,
  output logic              res_valid_o,
  output dec_result_t       res_o
);

  logic [ValueW-1:0] acc_shift;
  logic [LeftW-1:0]  left_dec;
  fmt_e              lead_kind;

  assign acc_shift = {state_i.acc[ValueW-ByteW-1:0], byte_i};
  assign left_dec  = state_i.left - LeftW'(1);
  assign lead_kind = fmt_e'(byte_i[5:4]);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.value = '0;
    res_o.len   = LenOneByte;
    if (state_i.left == '0) begin
      if (!byte_i[7]) begin
        res_valid_o = 1'b1;
        res_o.value = {{(ValueW-ByteW){1'b0}}, byte_i};
      end else if (byte_i[6]) begin
        res_valid_o = 1'b1;
        res_o.value = {{(ValueW-ByteW){1'b1}}, byte_i};
      end else begin
        state_o.kind = lead_kind;
        state_o.acc  = (lead_kind == FMT_32) ? '0 : {{(ValueW-4){1'b0}}, byte_i[3:0]};
        state_o.left = {1'b0, lead_kind} + LeftW'(1);
      end
    end else begin
      state_o.acc  = acc_shift;
      state_o.left = left_dec;
      if (left_dec == '0) begin
        res_valid_o = 1'b1;
        res_o.len   = {1'b0, state_i.kind} + LenW'(2);
        unique case (state_i.kind)
          FMT_12:  res_o.value = {{(ValueW-12){acc_shift[11]}}, acc_shift[11:0]};
          FMT_20:  res_o.value = {{(ValueW-20){acc_shift[19]}}, acc_shift[19:0]};
          FMT_28:  res_o.value = {{(ValueW-28){acc_shift[27]}}, acc_shift[27:0]};
          FMT_32:  res_o.value = acc_shift;
          default: res_o.value = acc_shift;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/svbd_out_reg.sv */
// Output register that holds one result and passes back-pressure upstream.
module svbd_out_reg
  import svbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  dec_result_t res_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        out_ready_i,
  output dec_result_t res_o
);

  logic        valid_q, valid_d;
  dec_result_t res_q;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* bench/signed_varint_byte_decoder_tb.sv */
// Self-checking testbench for the signed variable-length integer byte decoder.
module signed_varint_byte_decoder_tb;
  import svbd_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [ByteW-1:0] data;
    bit               hold;
  } stim_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [ByteW-1:0]    s_data = '0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  stim_t       byte_q[$];
  dec_result_t value_q[$];
  int unsigned err_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned in_cnt = 0;
  logic        calm;

  logic [ValueW-1:0] acc_st = '0;
  logic [LeftW-1:0]  left_st = '0;
  fmt_e              kind_st = FMT_12;

  signed_varint_byte_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  assign calm = (in_cnt >= 300) && (in_cnt < 450);

  function automatic logic [ValueW-1:0] extend_value(logic [ValueW-1:0] acc, fmt_e kind);
    case (kind)
      FMT_12: extend_value = {{20{acc[11]}}, acc[11:0]};
      FMT_20: extend_value = {{12{acc[19]}}, acc[19:0]};
      FMT_28: extend_value = {{4{acc[27]}}, acc[27:0]};
      default: extend_value = acc;
    endcase
  endfunction

  task automatic decode_byte(input logic [ByteW-1:0] b);
    dec_result_t res;
    if (left_st == '0) begin
      if (!b[7]) begin
        res.value = {24'd0, b};
        res.len   = LenOneByte;
        value_q.push_back(res);
      end else if (b[7:6] == 2'b11) begin
        res.value = {{24{1'b1}}, b};
        res.len   = LenOneByte;
        value_q.push_back(res);
      end else begin
        kind_st = fmt_e'(b[5:4]);
        acc_st  = (kind_st == FMT_32) ? '0 : {28'd0, b[3:0]};
        left_st = LeftW'(kind_st) + LeftW'(1);
      end
    end else begin
      acc_st  = {acc_st[23:0], b};
      left_st = left_st - LeftW'(1);
      if (left_st == '0) begin
        res.value = extend_value(acc_st, kind_st);
        res.len   = LenW'(kind_st) + LenW'(2);
        value_q.push_back(res);
      end
    end
  endtask

  task automatic add_byte(input logic [ByteW-1:0] b);
    stim_t s;
    s.data = b;
    s.hold = 1'b0;
    byte_q.push_back(s);
  endtask

  task automatic add_hold();
    stim_t s;
    s.data = '0;
    s.hold = 1'b1;
    byte_q.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    stim_t head;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        decode_byte(s_data);
        in_cnt <= in_cnt + 1;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (byte_q.size() != 0 && byte_q[0].hold) begin
          s_valid <= 1'b0;
          if (value_q.size() == 0 && !m_axis_tvalid_o) begin
            head = byte_q.pop_front();
          end
        end else if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
          head = byte_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= head.data;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    dec_result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (value_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports) begin
            $display("unexpected item: value %0d length %0d",
                     $signed(m_axis_tdata_o[ValueW-1:0]), m_axis_tdata_o[ValueW+:LenW]);
          end
        end else begin
          want = value_q.pop_front();
          if (m_axis_tdata_o[ValueW-1:0] !== want.value ||
              m_axis_tdata_o[ValueW+:LenW] !== want.len) begin
            err_cnt++;
            if (err_cnt <= MaxReports) begin
              $display("mismatch: value %0d length %0d, expected value %0d length %0d",
                       $signed(m_axis_tdata_o[ValueW-1:0]), m_axis_tdata_o[ValueW+:LenW],
                       $signed(want.value), want.len);
            end
          end
        end
      end
      m_ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt + 1 >= QuietLimit) begin
        $display("signed_varint_byte_decoder_tb: errors");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned k;
    logic [ByteW-1:0] b;
    bit held;
    held = 1'b0;

    add_byte(8'h00);
    add_byte(8'h7F);
    add_byte(8'hC0);
    add_byte(8'hFF);
    add_byte(8'h87); add_byte(8'hFF);
    add_byte(8'h88); add_byte(8'h00);
    add_byte(8'h97); add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'hA8); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_byte(8'hB5); add_byte(8'h7F); add_byte(8'hFF); add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'hB0); add_byte(8'h80); add_byte(8'h00); add_byte(8'h00); add_byte(8'h00);
    add_hold();

    while (byte_q.size() < 725) begin
      r = $urandom_range(99);
      if (r < 12) begin
        add_byte(ByteW'($urandom));
      end else if (r < 45) begin
        b = ByteW'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        add_byte(b);
      end else begin
        k = $urandom_range(3);
        add_byte({2'b10, 2'(k), 4'($urandom)});
        repeat (k + 1) add_byte(ByteW'($urandom));
      end
      if (!held && byte_q.size() > 380) begin
        add_hold();
        held = 1'b1;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_valid) @(posedge clk_i);
    while (value_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0 && value_q.size() == 0) begin
      $display("signed_varint_byte_decoder_tb: clean");
    end else begin
      $display("signed_varint_byte_decoder_tb: errors");
    end
    $finish;
  end

endmodule
